@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Operation and error codes, default sizes and the control word that the
// queue top broadcasts to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int OP_BITS  = 2;
  localparam int ERR_BITS = 2;

  // Operation codes of an input beat
  localparam logic [OP_BITS-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DEQ   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_BITS-1:0] OP_NOP   = 2'd3;

  // Error codes of a result beat
  localparam logic [ERR_BITS-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_FULL  = 2'd2;

  // Per-cycle command seen by all cells
  typedef struct packed {
    logic insert;  // place the new key, shifting larger keys toward the tail
    logic remove;  // shift every key one cell toward the head
  } cell_ctrl_t;

endpackage

@@ sv/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted key chain
// Holds one key, compares it with the broadcast key and either holds,
// takes the new key, takes its left neighbor's key or its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  logic                       occupied,
  input  logic signed [KEY_BITS-1:0] new_key,
  input  logic signed [KEY_BITS-1:0] left_key,
  input  logic                       left_gt,
  input  logic signed [KEY_BITS-1:0] right_key,
  output logic signed [KEY_BITS-1:0] key,
  output logic                       gt
);

  logic signed [KEY_BITS-1:0] key_r;
  logic signed [KEY_BITS-1:0] key_nxt;

  // Flag a held key that sorts after the new key
  assign gt  = occupied && (key_r > new_key);
  assign key = key_r;

  // Pick the next key: shift in from the left, drop in the new key, advance or hold
  always_comb begin
    key_nxt = key_r;
    if (ctrl.insert) begin
      if (left_gt) begin
        key_nxt = left_key;
      end else if (gt || !occupied) begin
        key_nxt = new_key;
      end
    end else if (ctrl.remove) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

@@ sv/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded minimum priority queue on a sorted chain
// Keys sit in a row of cells in ascending order; every cell compares the
// incoming key at once, so the whole chain updates at the edge taking a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_operation / in_priority_req and raise start; the
//   beat is taken at the clock edge where start is high and busy is low.
//   busy is never raised, so one beat can be taken every cycle.
//   Operations: enqueue a signed key, dequeue the smallest key, clear.
//   Result channel: exactly one result beat per input beat, in the cycle after
//   it is taken, shown for one cycle with out_valid high. out_value carries
//   the dequeued key (zero otherwise), out_value_valid marks it, out_error
//   reports dequeue from empty or enqueue into full (key dropped), and
//   out_occupancy gives the number of keys held afterwards.
//   Throughput 1 beat per cycle, set by the compare in each cell and the
//   one-step shift along the chain.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result strobe; the key cells themselves are not cleared.
//   The receiver cannot stall: a result beat is taken the cycle it appears.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
  parameter int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [spq_pkg::OP_BITS-1:0]  in_operation,
  input  logic signed [KEY_BITS-1:0]   in_priority_req,
  output logic                         out_valid,
  output logic signed [KEY_BITS-1:0]   out_value,
  output logic                         out_value_valid,
  output logic [spq_pkg::ERR_BITS-1:0] out_error,
  output logic [CNT_W-1:0]             out_occupancy
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                         accept;
  logic                         empty;
  logic                         full;
  spq_pkg::cell_ctrl_t          ctrl;
  logic signed [KEY_BITS-1:0]   key_q [DEPTH];
  logic                         gt    [DEPTH];
  logic                         occ   [DEPTH];

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         out_valid_r;
  logic signed [KEY_BITS-1:0]   out_value_r, out_value_nxt;
  logic                         out_value_valid_r, out_value_valid_nxt;
  logic [spq_pkg::ERR_BITS-1:0] out_error_r, out_error_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count_r == '0);
  assign full   = (count_r == FULL_CNT);

  // Decode the beat into the chain command, count update and result
  always_comb begin
    ctrl.insert         = 1'b0;
    ctrl.remove         = 1'b0;
    count_nxt           = count_r;
    out_value_nxt       = '0;
    out_value_valid_nxt = 1'b0;
    out_error_nxt       = spq_pkg::ERR_NONE;
    if (accept) begin
      case (in_operation)
        spq_pkg::OP_ENQ: begin
          if (full) begin
            out_error_nxt = spq_pkg::ERR_FULL;
          end else begin
            ctrl.insert = 1'b1;
            count_nxt   = count_r + 1'b1;
          end
        end
        spq_pkg::OP_DEQ: begin
          if (empty) begin
            out_error_nxt = spq_pkg::ERR_EMPTY;
          end else begin
            ctrl.remove         = 1'b1;
            count_nxt           = count_r - 1'b1;
            out_value_nxt       = key_q[0];
            out_value_valid_nxt = 1'b1;
          end
        end
        spq_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Build the chain; each cell sees its neighbors' keys and its left neighbor's compare flag
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_BITS-1:0] left_key;
    logic                       left_gt;
    logic signed [KEY_BITS-1:0] right_key;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_key = key_q[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = key_q[i];
    end else begin : g_inner
      assign right_key = key_q[i+1];
    end

    spq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ[i]),
      .new_key  (in_priority_req),
      .left_key (left_key),
      .left_gt  (left_gt),
      .right_key(right_key),
      .key      (key_q[i]),
      .gt       (gt[i])
    );
  end

  // Hold count and control; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    out_value_r       <= out_value_nxt;
    out_value_valid_r <= out_value_valid_nxt;
    out_error_r       <= out_error_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_value_valid = out_value_valid_r;
  assign out_error       = out_error_r;
  assign out_occupancy   = count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("taken beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without a taken beat");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (key_q[0] <= key_q[1]))
    else $error("head cells out of order");

  a_value_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_valid) |-> (out_error == spq_pkg::ERR_NONE))
    else $error("dequeued key reported with an error");

endmodule
